// ===== sv/oam_dma_bus_arbiter_unit_defines.svh =====
// Assertion macros used by the checker file.
`ifndef OAM_DMA_BUS_ARBITER_UNIT_DEFINES_SVH
`define OAM_DMA_BUS_ARBITER_UNIT_DEFINES_SVH

// Clocked assertion, muted while reset is asserted.
`define OAMDMA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define OAMDMA_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/oamdma_pkg.sv =====
package oamdma_pkg;

  typedef enum logic [1:0] {
    OpDmaWrite = 2'd0,
    OpStart    = 2'd1,
    OpTick     = 2'd2,
    OpAccess   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ActPass     = 2'd0,
    ActRedirect = 2'd1,
    ActBlock    = 2'd2
  } act_e;

  typedef struct packed {
    op_e         op;
    logic        is_write;
    logic [15:0] address;
    logic [7:0]  value;
    logic        vram_read_lock;
    logic        vram_write_lock;
    logic        sprite_read_lock;
    logic        sprite_write_lock;
  } item_t;

  typedef struct packed {
    act_e        access_action;
    logic [15:0] target_address;
    logic [15:0] copy_destination;
    logic        copy_valid;
    logic        transfer_done;
    logic [7:0]  dma_page;
    logic        dma_busy;
  } result_t;

endpackage

// ===== sv/oamdma_in_stage.sv =====
module oamdma_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                stall_o,
  input  oamdma_pkg::item_t   item_i,
  output logic                valid_o,
  input  logic                take_i,
  output oamdma_pkg::item_t   item_o
);

  logic              valid_q;
  oamdma_pkg::item_t item_q;
  logic              load;

  // stage can load when empty or when its item moves on this cycle
  assign stall_o = valid_q && !take_i;
  assign load    = valid_i && !stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== sv/oamdma_engine.sv =====
module oamdma_engine (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,
  input  logic                fire_i,
  input  oamdma_pkg::item_t   item_i,
  output oamdma_pkg::result_t result_o
);

  localparam logic [7:0]  FoldPage   = 8'hE0;
  localparam logic [7:0]  FoldOffset = 8'h20;
  localparam logic [7:0]  SpriteHi   = 8'hFE;
  localparam logic [7:0]  LastOffset = 8'h9F;
  localparam logic [15:0] VideoLo    = 16'h8000;
  localparam logic [15:0] VideoHi    = 16'h9FFF;
  localparam logic [15:0] SpriteLo   = 16'hFE00;
  localparam logic [15:0] SpriteEnd  = 16'hFE9F;
  localparam logic [15:0] MainLoEnd  = 16'h7FFF;
  localparam logic [15:0] MainHiLo   = 16'hA000;
  localparam logic [15:0] MainHiEnd  = 16'hDFFF;

  logic        rom_loaded_q;
  logic [7:0]  page_q, page_d;
  logic        pending_q, pending_d;
  logic        running_q, running_d;
  logic [15:0] src_q, src_d;
  logic        video_q, video_d;

  always_comb begin
    logic [7:0] pg;
    logic       a_video;
    logic       a_sprite;
    logic       a_main;
    logic       redirect;
    logic       blocked;

    page_d    = page_q;
    pending_d = pending_q;
    running_d = running_q;
    src_d     = src_q;
    video_d   = video_q;

    result_o                  = '0;
    result_o.access_action    = oamdma_pkg::ActPass;

    pg       = (item_i.value >= FoldPage) ? item_i.value - FoldOffset : item_i.value;
    a_video  = (item_i.address >= VideoLo) && (item_i.address <= VideoHi);
    a_sprite = (item_i.address >= SpriteLo) && (item_i.address <= SpriteEnd);
    a_main   = (item_i.address <= MainLoEnd) ||
               ((item_i.address >= MainHiLo) && (item_i.address <= MainHiEnd));
    redirect = 1'b0;
    blocked  = 1'b0;

    case (item_i.op)
      oamdma_pkg::OpDmaWrite: begin
        page_d = item_i.value;
        if (!running_q && !pending_q) begin
          src_d     = {pg, 8'h00};
          video_d   = ({pg, 8'h00} >= VideoLo) && ({pg, 8'h00} <= VideoHi);
          pending_d = 1'b1;
        end
      end
      oamdma_pkg::OpStart: begin
        if (pending_q) begin
          pending_d = 1'b0;
          running_d = 1'b1;
        end
      end
      oamdma_pkg::OpTick: begin
        if (running_q) begin
          result_o.target_address   = src_q;
          result_o.copy_destination = {SpriteHi, src_q[7:0]};
          result_o.copy_valid       = 1'b1;
          if (src_q[7:0] == LastOffset) begin
            running_d              = 1'b0;
            result_o.transfer_done = 1'b1;
          end else begin
            src_d = src_q + 16'd1;
          end
        end
      end
      oamdma_pkg::OpAccess: begin
        if (running_q) begin
          redirect = a_sprite || (video_q ? a_video : a_main);
        end
        if (redirect) begin
          result_o.access_action  = oamdma_pkg::ActRedirect;
          result_o.target_address = src_q;
        end else begin
          if (item_i.is_write) begin
            blocked = (rom_loaded_q && a_video && item_i.vram_write_lock) ||
                      (rom_loaded_q && a_sprite && item_i.sprite_write_lock);
          end else begin
            // sprite read lock applies even before program load
            blocked = (rom_loaded_q && a_video && item_i.vram_read_lock) ||
                      (a_sprite && item_i.sprite_read_lock);
          end
          result_o.access_action  = blocked ? oamdma_pkg::ActBlock : oamdma_pkg::ActPass;
          result_o.target_address = item_i.address;
        end
      end
      default: begin
      end
    endcase

    result_o.dma_page = page_d;
    result_o.dma_busy = pending_d || running_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rom_loaded_q <= 1'b0;
      page_q       <= '0;
      pending_q    <= 1'b0;
      running_q    <= 1'b0;
      src_q        <= '0;
      video_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        rom_loaded_q <= cfg_wdata_i;
      end
      if (fire_i) begin
        page_q    <= page_d;
        pending_q <= pending_d;
        running_q <= running_d;
        src_q     <= src_d;
        video_q   <= video_d;
      end
    end
  end

endmodule

// ===== sv/oamdma_out_stage.sv =====
module oamdma_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  oamdma_pkg::result_t result_i,
  output logic                valid_o,
  input  logic                stall_i,
  output oamdma_pkg::result_t result_o
);

  logic                valid_q;
  oamdma_pkg::result_t result_q;
  logic                load;

  assign ready_o = !valid_q || !stall_i;
  assign load    = valid_i && ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

// ===== sv/oam_dma_bus_arbiter_unit.sv =====
// Sprite-table DMA engine and CPU bus arbiter.
// Input channel (in_valid_i / in_stall_o) carries one item per bus event:
// DMA register write, start, transfer tick or CPU access. Every item
// produces exactly one result item on the output channel
// (out_valid_o / out_stall_i) with the access decision, addresses,
// copy strobes and the DMA page/busy status after that item.
// An accepted item passes two register stages (input register, result
// register) with the decode and DMA state update in between.
// Throughput: one item per cycle while the receiver does not stall.
// DMA state advances when an item moves from the input register into the
// result register, so results stay in input order.
// When the receiver stalls, the result register holds and the input
// register keeps one more item; in_stall_o rises only when both are full.
// Reset (rst_ni low, async) clears both stages, the DMA state and
// rom_loaded. cfg_we_i/cfg_wdata_i write rom_loaded; write only while idle.
module oam_dma_bus_arbiter_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic        is_write_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  value_i,
  input  logic        vram_read_lock_i,
  input  logic        vram_write_lock_i,
  input  logic        sprite_read_lock_i,
  input  logic        sprite_write_lock_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  access_action_o,
  output logic [15:0] target_address_o,
  output logic [15:0] copy_destination_o,
  output logic        copy_valid_o,
  output logic        transfer_done_o,
  output logic [7:0]  dma_page_o,
  output logic        dma_busy_o
);

  oamdma_pkg::item_t   in_item;
  oamdma_pkg::item_t   s1_item;
  oamdma_pkg::result_t eng_result;
  oamdma_pkg::result_t out_result;
  logic                s1_valid;
  logic                out_ready;
  logic                fire;

  always_comb begin
    in_item                   = '0;
    in_item.op                = oamdma_pkg::op_e'(operation_i);
    in_item.is_write          = is_write_i;
    in_item.address           = address_i;
    in_item.value             = value_i;
    in_item.vram_read_lock    = vram_read_lock_i;
    in_item.vram_write_lock   = vram_write_lock_i;
    in_item.sprite_read_lock  = sprite_read_lock_i;
    in_item.sprite_write_lock = sprite_write_lock_i;
  end

  assign fire = s1_valid && out_ready;

  oamdma_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .stall_o (in_stall_o),
    .item_i  (in_item),
    .valid_o (s1_valid),
    .take_i  (fire),
    .item_o  (s1_item)
  );

  oamdma_engine u_eng (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (fire),
    .item_i      (s1_item),
    .result_o    (eng_result)
  );

  oamdma_out_stage u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s1_valid),
    .ready_o  (out_ready),
    .result_i (eng_result),
    .valid_o  (out_valid_o),
    .stall_i  (out_stall_i),
    .result_o (out_result)
  );

  assign access_action_o    = out_result.access_action;
  assign target_address_o   = out_result.target_address;
  assign copy_destination_o = out_result.copy_destination;
  assign copy_valid_o       = out_result.copy_valid;
  assign transfer_done_o    = out_result.transfer_done;
  assign dma_page_o         = out_result.dma_page;
  assign dma_busy_o         = out_result.dma_busy;

endmodule

// ===== sv/oamdma_checker.sv =====
`include "oam_dma_bus_arbiter_unit_defines.svh"

module oamdma_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic [1:0]  access_action_o,
  input logic [15:0] copy_destination_o,
  input logic        copy_valid_o,
  input logic        transfer_done_o,
  input logic        dma_busy_o
);

  logic action_ok;
  logic redirect_seen;
  logic copy_seen;
  logic done_seen;
  logic dest_ok;
  logic end_ok;

  assign action_ok     = (access_action_o <= oamdma_pkg::ActBlock);
  assign redirect_seen = out_valid_o && (access_action_o == oamdma_pkg::ActRedirect);
  assign copy_seen     = out_valid_o && copy_valid_o;
  assign done_seen     = out_valid_o && transfer_done_o;
  assign dest_ok       = (copy_destination_o[15:8] == 8'hFE) &&
                         (copy_destination_o[7:0] <= 8'h9F);
  assign end_ok        = copy_valid_o && (copy_destination_o[7:0] == 8'h9F) && !dma_busy_o;

  `OAMDMA_ASSERT_RST(a_no_out_in_reset, clk_i, !rst_ni |-> !out_valid_o, "result item in reset")

  `OAMDMA_ASSERT(a_action_code, clk_i, rst_ni, out_valid_o |-> action_ok, "bad action code")

  `OAMDMA_ASSERT(a_redirect_busy, clk_i, rst_ni, redirect_seen |-> dma_busy_o, "redirect while idle")

  `OAMDMA_ASSERT(a_copy_dest, clk_i, rst_ni, copy_seen |-> dest_ok, "copy outside sprite table")

  `OAMDMA_ASSERT(a_done_end, clk_i, rst_ni, done_seen |-> end_ok, "bad transfer end")

endmodule

bind oam_dma_bus_arbiter_unit oamdma_checker u_oamdma_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_o        (out_valid_o),
  .access_action_o    (access_action_o),
  .copy_destination_o (copy_destination_o),
  .copy_valid_o       (copy_valid_o),
  .transfer_done_o    (transfer_done_o),
  .dma_busy_o         (dma_busy_o)
);
